>>> hw/rtl/uuidg_pkg.sv
// ----------------------------------------------------------------------------
// uuidg_pkg
// Shared types, constants and character helpers for the uuid string generator
// ----------------------------------------------------------------------------
package uuidg_pkg;

    // string geometry
    localparam int UUID_LEN = 36;
    localparam int POS_W    = 6;
    localparam logic [POS_W-1:0] LAST_POS = 6'd35;

    // fixed characters
    localparam logic [6:0] CHAR_HYPHEN = 7'h2d;
    localparam logic [6:0] CHAR_FOUR   = 7'h34;
    localparam logic [6:0] CHAR_ZERO   = 7'h30;
    localparam logic [6:0] CHAR_A_OFS  = 7'h57;   // 'a' - 10

    // configuration register indexes
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_FIRST  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_SECOND = 8'd1;

    // seed reset values
    localparam logic [63:0] SEED_FIRST_RST  = 64'd1;
    localparam logic [63:0] SEED_SECOND_RST = 64'd2;

    // character class of one string position
    typedef enum logic [1:0] {
        CLS_HEX     = 2'd0,
        CLS_VARIANT = 2'd1,
        CLS_HYPHEN  = 2'd2,
        CLS_FOUR    = 2'd3
    } char_cls_t;

    // two random words handed from front to back
    typedef struct packed {
        logic [63:0] word_hi;
        logic [63:0] word_lo;
    } words_t;

    // pattern xxxxxxxx-xxxx-4xxx-yxxx-xxxxxxxxxxxx
    function automatic char_cls_t char_class(input logic [POS_W-1:0] pos);
        char_cls_t cls;
        unique case (pos)
            6'd8, 6'd13, 6'd18, 6'd23: cls = CLS_HYPHEN;
            6'd14:                     cls = CLS_FOUR;
            6'd19:                     cls = CLS_VARIANT;
            default:                   cls = CLS_HEX;
        endcase
        return cls;
    endfunction

    // lowercase hex digit
    function automatic logic [6:0] hex_char(input logic [3:0] n);
        logic [6:0] code;
        if (n < 4'd10) begin
            code = CHAR_ZERO + {3'd0, n};
        end else begin
            code = CHAR_A_OFS + {3'd0, n};
        end
        return code;
    endfunction

endpackage

>>> hw/rtl/uuidg_front.sv
// ----------------------------------------------------------------------------
// uuidg_front
// Request intake: seed registers, xorshift128+ state, two draws per item
// ----------------------------------------------------------------------------
module uuidg_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    // config write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [uuidg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                     cfg_data,
    // request channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_reload_seed,
    // queue push side
    input  logic                            q_full,
    output logic                            q_push,
    output uuidg_pkg::words_t               q_words
);

    logic [63:0] seed_first_reg,  seed_first_next;
    logic [63:0] seed_second_reg, seed_second_next;
    logic [63:0] state0_reg, state0_next;
    logic [63:0] state1_reg, state1_next;
    logic [63:0] a0, b0, s1_a, s1_b;
    logic        accept;

    // new second state word of one xorshift128+ step
    function automatic logic [63:0] xs_mix(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] t;
        t = a ^ (a << 23);
        return t ^ b ^ (t >> 18) ^ (b >> 5);
    endfunction

    assign cfg_ready = 1'b1;
    assign s_ready   = !q_full;
    assign accept    = s_valid && s_ready;
    assign q_push    = accept;

    // two chained generator steps, adds run side by side
    always_comb begin
        a0   = s_reload_seed ? seed_first_reg  : state0_reg;
        b0   = s_reload_seed ? seed_second_reg : state1_reg;
        s1_a = xs_mix(a0, b0);
        s1_b = xs_mix(b0, s1_a);
        q_words.word_lo = s1_a + b0;
        q_words.word_hi = s1_b + s1_a;
    end

    // seed register writes
    always_comb begin
        seed_first_next  = seed_first_reg;
        seed_second_next = seed_second_reg;
        if (cfg_valid && cfg_ready) begin
            if (cfg_index == uuidg_pkg::CFG_SEED_FIRST) begin
                seed_first_next = cfg_data;
            end else if (cfg_index == uuidg_pkg::CFG_SEED_SECOND) begin
                seed_second_next = cfg_data;
            end
        end
    end

    // generator state advances by two steps per item
    always_comb begin
        state0_next = state0_reg;
        state1_next = state1_reg;
        if (accept) begin
            state0_next = s1_a;
            state1_next = s1_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_first_reg  <= uuidg_pkg::SEED_FIRST_RST;
            seed_second_reg <= uuidg_pkg::SEED_SECOND_RST;
            state0_reg      <= uuidg_pkg::SEED_FIRST_RST;
            state1_reg      <= uuidg_pkg::SEED_SECOND_RST;
        end else begin
            seed_first_reg  <= seed_first_next;
            seed_second_reg <= seed_second_next;
            state0_reg      <= state0_next;
            state1_reg      <= state1_next;
        end
    end

    // assertions
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full) else $error("push into full queue");
    a_reseed_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_reload_seed) |=> (state0_reg == xs_mix($past(seed_first_reg),
        $past(seed_second_reg)))) else $error("reseed did not take seed registers");
    a_idle_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> ($stable(state0_reg) && $stable(state1_reg)))
        else $error("generator moved without an item");

endmodule

>>> hw/rtl/uuidg_fifo.sv
// ----------------------------------------------------------------------------
// uuidg_fifo
// Short register queue of random word pairs between front and back
// ----------------------------------------------------------------------------
module uuidg_fifo #(
    parameter int DEPTH = 2
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  uuidg_pkg::words_t push_data,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output uuidg_pkg::words_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    uuidg_pkg::words_t mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg,  count_next;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // assertions
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_FULL) else $error("queue count out of range");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty) else $error("pop from empty queue");
    a_ptr_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with unequal pointers");

endmodule

>>> hw/rtl/uuidg_back.sv
// ----------------------------------------------------------------------------
// uuidg_back
// String formatter: turns one word pair into 36 characters; while m_ready is high, one per cycle
// ----------------------------------------------------------------------------
module uuidg_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    // queue pop side
    input  logic                         q_not_empty,
    input  uuidg_pkg::words_t            q_words,
    output logic                         q_pop,
    // result channel
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [6:0]                   m_char_code,
    output logic                         m_last
);

    logic                         active_reg, active_next;
    logic [uuidg_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [127:0]                 nib_reg, nib_next;
    logic                         m_valid_reg, m_valid_next;
    logic [6:0]                   code_reg, code_next;
    logic                         last_reg, last_next;
    uuidg_pkg::char_cls_t         cls;
    logic [3:0]                   nib;
    logic [6:0]                   cur_code;
    logic                         advance, at_end;

    assign m_valid     = m_valid_reg;
    assign m_char_code = code_reg;
    assign m_last      = last_reg;

    assign advance = active_reg && (!m_valid_reg || m_ready);
    assign at_end  = (pos_reg == uuidg_pkg::LAST_POS);
    assign q_pop   = q_not_empty && (!active_reg || (advance && at_end));

    // character for the current position
    always_comb begin
        cls = uuidg_pkg::char_class(pos_reg);
        nib = nib_reg[3:0];
        unique case (cls)
            uuidg_pkg::CLS_HEX:     cur_code = uuidg_pkg::hex_char(nib);
            uuidg_pkg::CLS_VARIANT: cur_code = uuidg_pkg::hex_char({2'b10, nib[1:0]});
            uuidg_pkg::CLS_HYPHEN:  cur_code = uuidg_pkg::CHAR_HYPHEN;
            uuidg_pkg::CLS_FOUR:    cur_code = uuidg_pkg::CHAR_FOUR;
            default:                cur_code = uuidg_pkg::CHAR_HYPHEN;
        endcase
    end

    // sequencing of positions and the output register
    always_comb begin
        active_next  = active_reg;
        pos_next     = pos_reg;
        nib_next     = nib_reg;
        m_valid_next = m_valid_reg;
        code_next    = code_reg;
        last_next    = last_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (advance) begin
            m_valid_next = 1'b1;
            code_next    = cur_code;
            last_next    = at_end;
            pos_next     = pos_reg + 1'b1;
            if (cls == uuidg_pkg::CLS_HEX || cls == uuidg_pkg::CLS_VARIANT) begin
                nib_next = nib_reg >> 4;
            end
            if (at_end) begin
                active_next = 1'b0;
                pos_next    = '0;
            end
        end
        if (q_pop) begin
            active_next = 1'b1;
            pos_next    = '0;
            nib_next    = q_words;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            active_reg  <= active_next;
            pos_reg     <= pos_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        nib_reg  <= nib_next;
        code_reg <= code_next;
        last_reg <= last_next;
    end

    // assertions
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= uuidg_pkg::LAST_POS) else $error("position out of range");
    a_four_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && pos_reg == 6'd14) |=> (code_reg == uuidg_pkg::CHAR_FOUR))
        else $error("version digit misplaced");
    a_last_end: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> (last_reg == ($past(pos_reg) == uuidg_pkg::LAST_POS)))
        else $error("last flag on wrong character");

endmodule

>>> hw/rtl/uuid_v4_string_generator.sv
// ----------------------------------------------------------------------------
// uuid_v4_string_generator
// Version-4 UUID string source driven by a xorshift128+ generator
// ----------------------------------------------------------------------------
// Usage:
//   Each item on the s_ channel requests one UUID string. s_reload_seed = 1
//   loads the generator state from the two seed registers before drawing.
//   The m_ channel returns 36 items, one ASCII character each, in the form
//   xxxxxxxx-xxxx-4xxx-yxxx-xxxxxxxxxxxx; m_last marks the 36th.
//   The cfg channel writes seed_first (index 0) and seed_second (index 1);
//   other indexes are ignored. cfg_ready is always high; write only when idle.
//   A request's word pair is queued, then loaded into the formatter's
//   nibble register, before its first character is registered.
//   Throughput: one character per cycle while m_ready is high. A short queue of
//   drawn word pairs lets requests be taken while a string is still going out.
//   Reset: seeds return to 1 and 2, generator state to the same, queue empty.
//   A stalled m_ready holds the current character; the queue fills, then
//   s_ready drops until the formatter moves on.
// ----------------------------------------------------------------------------
module uuid_v4_string_generator #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [uuidg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                     cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_reload_seed,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [6:0]                      m_char_code,
    output logic                            m_last
);

    logic              q_push, q_full, q_pop, q_not_empty;
    uuidg_pkg::words_t push_words, pop_words;

    // request intake and generator
    uuidg_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_reload_seed (s_reload_seed),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_words       (push_words)
    );

    // word pair queue
    uuidg_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (push_words),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (pop_words)
    );

    // string formatter
    uuidg_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_words     (pop_words),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_char_code (m_char_code),
        .m_last      (m_last)
    );

endmodule
